// ===== hw/rtl/four_level_page_table_mapper_assert.svh =====
// Assertion macros for the page-table mapper.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
// implication checked at every clock edge outside reset
`define FLPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication from reset onward, reset included
`define FLPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ===== hw/rtl/flpt_pkg.sv =====
// Package for the page-table mapper: constants, entry flags, status codes.
// No dependencies.
package flpt_pkg;
  localparam int unsigned PoolFramesDef = 64;
  localparam int unsigned BootDirsDef   = 4;
  localparam int unsigned IdxW          = 9;
  localparam int unsigned EntriesPerTbl = 512;
  localparam logic [63:0] AddrMask  = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] PgP       = 64'h01;
  localparam logic [63:0] PgRw      = 64'h02;
  localparam logic [63:0] PgUs      = 64'h04;
  localparam logic [63:0] PgPwt     = 64'h08;
  localparam logic [63:0] PgPcd     = 64'h10;
  localparam logic [63:0] PgPs      = 64'h80;
  localparam logic [63:0] LinkFlags = PgP | PgRw | PgUs;
  localparam logic [63:0] LapicAddr  = 64'hFEE0_0000;
  localparam logic [63:0] IoapicAddr = 64'hFEC0_0000;
  localparam logic [IdxW-1:0] LapicSlot  = 9'd503;
  localparam logic [IdxW-1:0] IoapicSlot = 9'd502;
  localparam logic [39:0] BaseReset = 40'd256;

  typedef enum logic [2:0] {
    StMapped   = 3'd0,
    StMerged   = 3'd1,
    StNoFrame  = 3'd2,
    StNoInit   = 3'd3,
    StInitDone = 3'd4
  } status_e;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [47:0] virtual_address;
    logic [51:0] physical_address;
    logic [31:0] page_flags;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [0:0]  flush_valid;
    logic [47:0] flush_address;
  } rsp_t;
endpackage

// ===== hw/rtl/flpt_req_if.sv =====
// Request and response channel interfaces, valid/ready handshake.
// Depends on flpt_pkg.
interface flpt_req_if import flpt_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface flpt_rsp_if import flpt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/flpt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module flpt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/four_level_page_table_mapper.sv =====
// Four-level page-table mapper: keeps a pool of 4 KB table frames (512 entries of 64 bit)
// in one single-port RAM and walks or builds them with a small sequencer. All table
// traffic goes through that one RAM port, one entry per cycle. A map request reads each
// table level through the issue, wait and evaluate states, and zeroes and links each new
// table frame it needs; the leaf entry is written without a read, and a 2 MB entry found
// at the directory level is merged in place. The init request rewrites the boot frames:
// it zeroes them, writes the links, fills the identity 2 MB entries and, with four boot directories, the APIC entries.
// The block takes no request while one is in progress. No clearing pass after reset.
// Depends on flpt_pkg, flpt_req_if/flpt_rsp_if, flpt_ram and the assertion header.
`include "four_level_page_table_mapper_assert.svh"

module four_level_page_table_mapper import flpt_pkg::*; #(
  parameter int unsigned PoolFrames = PoolFramesDef,
  parameter int unsigned BootDirs   = BootDirsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [39:0]  cfg_wdata_i,
  flpt_req_if.sink     req,
  flpt_rsp_if.source   rsp
);
  localparam int unsigned FrW   = $clog2(PoolFrames);
  localparam int unsigned CntW  = FrW + 1;
  localparam int unsigned AddrW = FrW + IdxW;
  localparam int unsigned BootFrames = 2 + BootDirs;

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SZero  = 10'b0000000010,  // zero boot frames
    SLink  = 10'b0000000100,  // write top and next-level links
    SFill  = 10'b0000001000,  // identity 2 MB entries
    SApic  = 10'b0000010000,
    SRead  = 10'b0000100000,  // issue read of level entry, or write leaf entry
    SWait  = 10'b0001000000,
    SEval  = 10'b0010000000,
    SNew   = 10'b0100000000,  // zero a new frame, then link it
    SResp  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [39:0]     base_q;
  logic [CntW-1:0] nff_q, nff_d;
  logic            init_q, init_d;
  req_t            req_q;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic [1:0]      lvl_q, lvl_d;       // 0 top .. 3 leaf
  logic [FrW-1:0]  frm_q, frm_d;       // frame holding current level's table
  logic [FrW-1:0]  nfr_q, nfr_d;       // frame being zeroed
  logic [CntW-1:0] zf_q, zf_d;         // boot frame / directory counter
  logic [IdxW-1:0] idx_q, idx_d;
  logic [63:0]     ent_q, ent_d;

  logic            we;
  logic [AddrW-1:0] addr;
  logic [63:0]     wdata, rdata;

  flpt_ram #(.Width(64), .Depth(PoolFrames * EntriesPerTbl)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  function automatic logic [63:0] frame_addr(logic [39:0] base, logic [FrW-1:0] f);
    logic [39:0] s;
    s = base + 40'(f);
    return {12'd0, s, 12'd0};
  endfunction

  logic [IdxW-1:0] lvl_idx;
  always_comb begin
    case (lvl_q)
      2'd0:    lvl_idx = req_q.virtual_address[47:39];
      2'd1:    lvl_idx = req_q.virtual_address[38:30];
      2'd2:    lvl_idx = req_q.virtual_address[29:21];
      default: lvl_idx = req_q.virtual_address[20:12];
    endcase
  end

  // pointer-to-pool-frame check on the entry just read (or just written)
  logic [39:0] off;
  logic        off_ok;
  assign off    = ent_q[51:12] - base_q;
  assign off_ok = (off < 40'(nff_q)) && (off < 40'(PoolFrames));

  always_comb begin
    state_d = state_q; nff_d = nff_q; init_d = init_q;
    rsp_d = rsp_q; rsp_valid_d = rsp_valid_q;
    lvl_d = lvl_q; frm_d = frm_q; nfr_d = nfr_q; zf_d = zf_q; idx_d = idx_q;
    ent_d = ent_q;
    we = 1'b0; addr = '0; wdata = '0;
    if (rsp_valid_q && rsp.ready) rsp_valid_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (req.valid && !rsp_valid_q) begin
          if (req.payload.cmd[0]) begin
            state_d = SZero; zf_d = '0; idx_d = '0;
          end else if (!init_q) begin
            rsp_d = '{status: StNoInit, flush_valid: 1'b0, flush_address: '0};
            state_d = SResp;
          end else begin
            lvl_d = 2'd0; frm_d = '0; state_d = SRead;
          end
        end
      end
      SZero: begin
        we = 1'b1; addr = {zf_q[FrW-1:0], idx_q};
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(EntriesPerTbl - 1)) begin
          zf_d = zf_q + 1'b1;
          if (zf_q == CntW'(BootFrames - 1)) begin
            state_d = SLink; zf_d = '0;
          end
        end
      end
      SLink: begin
        we = 1'b1;
        if (zf_q == '0) begin
          addr = '0; wdata = frame_addr(base_q, FrW'(1)) | LinkFlags;
        end else begin
          addr  = {FrW'(1), IdxW'(zf_q - 1'b1)};
          wdata = frame_addr(base_q, FrW'(zf_q + 1'b1)) | LinkFlags;
        end
        zf_d = zf_q + 1'b1;
        if (zf_q == CntW'(BootDirs)) begin
          zf_d = '0; idx_d = '0; state_d = SFill;
        end
      end
      SFill: begin
        we = 1'b1; addr = {FrW'(zf_q + 2'd2), idx_q};
        wdata = {32'd0, zf_q[1:0], idx_q, 21'd0} | LinkFlags | PgPs;
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(EntriesPerTbl - 1)) begin
          zf_d = zf_q + 1'b1;
          if (zf_q == CntW'(BootDirs - 1)) begin
            zf_d = '0;
            if (BootDirs == 4) state_d = SApic;
            else begin
              init_d = 1'b1;
              rsp_d = '{status: StInitDone, flush_valid: 1'b0, flush_address: '0};
              state_d = SResp;
            end
          end
        end
      end
      SApic: begin
        we = 1'b1;
        addr  = {FrW'(5), (zf_q[0] ? IoapicSlot : LapicSlot)};
        wdata = (zf_q[0] ? IoapicAddr : LapicAddr) | PgP | PgRw | PgPcd | PgPwt | PgPs;
        zf_d = zf_q + 1'b1;
        if (zf_q[0]) begin
          init_d = 1'b1;
          rsp_d = '{status: StInitDone, flush_valid: 1'b0, flush_address: '0};
          state_d = SResp;
        end
      end
      SRead: begin
        addr = {frm_q, lvl_idx};
        if (lvl_q == 2'd3) begin
          we = 1'b1;
          wdata = ({12'd0, req_q.physical_address} & AddrMask) | {32'd0, req_q.page_flags};
          rsp_d = '{status: StMapped, flush_valid: 1'b1,
                    flush_address: req_q.virtual_address};
          state_d = SResp;
        end else begin
          state_d = SWait;
        end
      end
      SWait: begin
        addr = {frm_q, lvl_idx};
        ent_d = rdata;
        state_d = SEval;
      end
      SEval: begin
        addr = {frm_q, lvl_idx};
        if (lvl_q == 2'd2 && ent_q[7]) begin
          we = 1'b1; wdata = ent_q | {32'd0, req_q.page_flags};
          rsp_d = '{status: StMerged, flush_valid: 1'b1,
                    flush_address: req_q.virtual_address};
          state_d = SResp;
        end else if (!ent_q[0]) begin
          if (nff_q >= CntW'(PoolFrames)) begin
            rsp_d = '{status: StNoFrame, flush_valid: 1'b0, flush_address: '0};
            state_d = SResp;
          end else begin
            nfr_d = nff_q[FrW-1:0]; nff_d = nff_q + 1'b1;
            idx_d = '0; state_d = SNew;
          end
        end else if (!off_ok) begin
          rsp_d = '{status: StNoFrame, flush_valid: 1'b0, flush_address: '0};
          state_d = SResp;
        end else begin
          frm_d = off[FrW-1:0]; lvl_d = lvl_q + 1'b1; state_d = SRead;
        end
      end
      SNew: begin
        we = 1'b1; addr = {nfr_q, idx_q};
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(EntriesPerTbl - 1)) begin
          // link goes in on the following cycle through SEval
          ent_d = frame_addr(base_q, nfr_q) | LinkFlags;
          state_d = SWait;
        end
      end
      SResp: begin
        rsp_valid_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    // new frame: write link once zeroing is done (SEval after SNew reuses ent)
    if (state_q == SNew && idx_q == IdxW'(EntriesPerTbl - 1)) begin
      state_d = SEval;
    end
    if (state_q == SEval && ent_q[0] == 1'b1 && !(lvl_q == 2'd2 && ent_q[7]) &&
        ent_q == (frame_addr(base_q, nfr_q) | LinkFlags) && nfr_q == nff_q[FrW-1:0] - 1'b1
        && nff_q != '0 && state_d == SRead && we == 1'b0) begin
      we = 1'b1; wdata = ent_q;
    end
  end

  assign req.ready = (state_q == SIdle) && !rsp_valid_q;
  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; base_q <= BaseReset; nff_q <= CntW'(BootFrames);
      init_q <= 1'b0; rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; nff_q <= nff_d; init_q <= init_d; rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d; lvl_q <= lvl_d; frm_q <= frm_d; nfr_q <= nfr_d;
    zf_q <= zf_d; idx_q <= idx_d; ent_q <= ent_d;
    if (req.valid && req.ready) req_q <= req.payload;
  end

  // a flush goes with a mapped or merged response only
  logic rsp_flush_ok;
  assign rsp_flush_ok = rsp.payload.flush_valid ==
                        (rsp.payload.status == StMapped || rsp.payload.status == StMerged);

  `FLPT_ASSERT(a_no_accept_busy, (state_q != SIdle) |-> !req.ready, "request taken while busy")
  `FLPT_ASSERT(a_alloc_bound, nff_q <= CntW'(PoolFrames), "allocator past pool")
  `FLPT_ASSERT(a_flush_status, rsp.valid |-> rsp_flush_ok, "flush and status disagree")
  `FLPT_ASSERT(a_init_sticky, $past(init_q) |-> init_q, "init flag dropped")
endmodule
